// ----- sv/assert_macros.svh -----
// Assertion macros used by the top-level RTL. Define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define GEM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gem assertion failed");

// Next-cycle implication.
`define GEM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gem assertion failed");

`else

`define GEM_ASSERT_IMP(label, clk, rst, ante, cons)
`define GEM_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- sv/gem_pkg.sv -----
`default_nettype none

package gem_pkg;

   // Buffer geometry
   localparam int PENDING_DEPTH = 32;
   localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

   // Field widths
   localparam int TIME_W = 32;
   localparam int GL_W   = 10;
   localparam int LIM_W  = 16;
   localparam int MIN_W  = 10;
   localparam int WARM_W = 3;
   localparam int POS_W  = 3;
   localparam int IDX_W  = 3;
   localparam int CSR_W  = 16;

   // Register indexes
   localparam logic [IDX_W-1:0] REG_RISE      = 3'd0;
   localparam logic [IDX_W-1:0] REG_FLOOR     = 3'd1;
   localparam logic [IDX_W-1:0] REG_LOOKAHEAD = 3'd2;
   localparam logic [IDX_W-1:0] REG_HOLD      = 3'd3;
   localparam logic [IDX_W-1:0] REG_WARMUP    = 3'd4;

   // Register reset values
   localparam logic [GL_W-1:0]   RISE_RST      = 10'd70;
   localparam logic [GL_W-1:0]   FLOOR_RST     = 10'd70;
   localparam logic [LIM_W-1:0]  LOOKAHEAD_RST = 16'd7200;
   localparam logic [MIN_W-1:0]  HOLD_MIN_RST  = 10'd15;
   localparam logic [WARM_W-1:0] WARMUP_RST    = 3'd3;
   localparam logic [POS_W-1:0]  POS_MAX       = 3'd7;

   // One buffered sample
   typedef struct packed {
      logic [TIME_W-1:0] smp_time;
      logic [GL_W-1:0]   smp_gl;
      logic              smp_miss;
      logic              smp_mark;
   } entry_type;

   // Scan token handed from cell to cell
   typedef struct packed {
      logic vld;
      logic closed;
      logic rise;
      logic hbreak;
   } link_type;

   // Head values broadcast to every cell during a scan
   typedef struct packed {
      logic [TIME_W-1:0] head_time;
      logic [GL_W:0]     rise_lim;
      logic [LIM_W-1:0]  lookahead;
      logic [LIM_W-1:0]  hold_secs;
   } bcast_type;

   // Per-cell control
   typedef struct packed {
      logic live;
      logic load;
      logic pop;
      logic apply;
   } cell_ctl_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOAD   = 5'b00010,
      ST_PASS   = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_FLUSH  = 5'b10000
   } state_type;

   // Signed time difference later - earlier strictly above a non-negative limit
   function automatic logic exceeds(input logic [TIME_W-1:0] later,
                                    input logic [TIME_W-1:0] earlier,
                                    input logic [LIM_W-1:0]  limit);
      logic [TIME_W:0] diff;
      diff = {1'b0, later} - {1'b0, earlier};
      return !diff[TIME_W] && (diff[TIME_W-1:0] > {{(TIME_W-LIM_W){1'b0}}, limit});
   endfunction

   // minutes * 60 as (m << 6) - (m << 2)
   function automatic logic [LIM_W-1:0] minutes_to_secs(input logic [MIN_W-1:0] m);
      logic [LIM_W-1:0] wide;
      wide = {{(LIM_W-MIN_W){1'b0}}, m};
      return (wide << 6) - (wide << 2);
   endfunction

endpackage

`default_nettype wire

// ----- sv/gem_cell.sv -----
`default_nettype none

module gem_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  gem_pkg::cell_ctl_type ctl,
   input  gem_pkg::bcast_type    bcast,
   input  gem_pkg::entry_type    ins_entry,
   input  gem_pkg::entry_type    nxt_entry,
   input  logic                  nxt_tent,
   input  gem_pkg::link_type     link_prev,
   output gem_pkg::entry_type    entry,
   output logic                  tent,
   output gem_pkg::link_type     link_out
);
   import gem_pkg::*;

   entry_type entry_ff, entry_in;
   logic      tent_ff, tent_in;
   link_type  tok_ff, tok_in;
   logic      over_la, over_hold, rise_hit;

   // Compare own sample against the broadcast head
   always_comb begin
      over_la   = exceeds(entry_ff.smp_time, bcast.head_time, bcast.lookahead);
      over_hold = exceeds(entry_ff.smp_time, bcast.head_time, bcast.hold_secs);
      rise_hit  = !entry_ff.smp_miss && ({1'b0, entry_ff.smp_gl} > bcast.rise_lim);
   end

   // Token update: rise only counts before the first look-ahead break
   always_comb begin
      tok_in = link_prev;
      if (link_prev.vld && ctl.live) begin
         tok_in.closed = link_prev.closed | over_la;
         tok_in.rise   = link_prev.rise | (!link_prev.closed && !over_la && rise_hit);
         tok_in.hbreak = link_prev.hbreak | over_hold;
      end
   end

   // Tentative mark: inside the hold with no earlier break
   always_comb begin
      tent_in = tent_ff;
      if (link_prev.vld) begin
         tent_in = !link_prev.hbreak && !over_hold;
      end
   end

   // Pop shifts headward, ORing in nxt_tent on apply; load takes ins_entry
   always_comb begin
      entry_in = entry_ff;
      if (ctl.pop) begin
         entry_in = nxt_entry;
         entry_in.smp_mark = nxt_entry.smp_mark | (ctl.apply & nxt_tent);
      end else if (ctl.load) begin
         entry_in = ins_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      tent_ff  <= tent_in;
   end

   assign entry    = entry_ff;
   assign tent     = tent_ff;
   assign link_out = tok_ff;

endmodule

`default_nettype wire

// ----- sv/glucose_excursion_marker_top.sv -----
// Channel | Dir | Handshake          | Payload
// req     | in  | req_valid/ready    | sample_time, glucose, glucose_missing, series_end
// rsp     | out | rsp_valid/ready    | out_time .. run_last
// csr     | in  | csr_valid/ready    | csr_index, csr_data (always ready)
//
// One sample at a time. Each scan of the cell chain starts a token, passes it
// on one cell per cycle, and then decides on the head sample. Every result adds
// one more scan, except the one that drains the buffer; an item with results ends
// with a flush of its last beat. A full buffer adds one scan and one more pass
// through load before the new sample is stored.
// Synchronous reset clears control state; buffer contents are not cleared.
// A stalled rsp beat holds the sequencer in decide or flush until the output frees up.
`default_nettype none

`include "assert_macros.svh"

module glucose_excursion_marker_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gem_pkg::TIME_W-1:0]    req_sample_time,
   input  logic [gem_pkg::GL_W-1:0]      req_glucose,
   input  logic                          req_glucose_missing,
   input  logic                          req_series_end,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gem_pkg::TIME_W-1:0]    rsp_out_time,
   output logic [gem_pkg::GL_W-1:0]      rsp_out_glucose,
   output logic                          rsp_out_missing,
   output logic                          rsp_excursion,
   output logic                          rsp_onset,
   output logic                          rsp_series_last,
   output logic                          rsp_run_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gem_pkg::IDX_W-1:0]     csr_index,
   input  logic [gem_pkg::CSR_W-1:0]     csr_data
);
   import gem_pkg::*;

   typedef struct packed {
      logic [TIME_W-1:0] smp_time;
      logic [GL_W-1:0]   smp_gl;
      logic              smp_miss;
      logic              exc;
      logic              start;
      logic              slast;
   } held_type;

   // Configuration
   logic [GL_W-1:0]   rise_ff, rise_in;
   logic [GL_W-1:0]   floor_ff, floor_in;
   logic [LIM_W-1:0]  la_ff, la_in;
   logic [LIM_W-1:0]  hold_secs_ff, hold_secs_in;
   logic [WARM_W-1:0] warm_ff, warm_in;

   // Sequencer and series state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              prev_ok_ff, prev_ok_in;
   logic [TIME_W-1:0] trig_time_ff, trig_time_in;
   logic              trig_act_ff, trig_act_in;
   logic              last_exc_ff, last_exc_in;
   logic              forced_ff, forced_in;
   logic              end_ff, end_in;
   logic              start_ff, start_in;
   link_type          fin_ff, fin_in;
   entry_type         ins_ff, ins_in;
   held_type          held_ff, held_in;
   logic              held_vld_ff, held_vld_in;
   held_type          rsp_pay_ff, rsp_pay_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Chain wiring
   entry_type    cell_entry [PENDING_DEPTH];
   logic         cell_tent  [PENDING_DEPTH];
   link_type     cell_link  [PENDING_DEPTH];
   cell_ctl_type cell_ctl   [PENDING_DEPTH];
   bcast_type    bcast;
   link_type     link_start;

   entry_type head;
   logic      full, elig, apply, emit, out_free, dec_go, pop;
   logic      exc, send_held, send_last, req_acc;

   assign head     = cell_entry[0];
   assign full     = (count_ff == CNT_W'(PENDING_DEPTH));
   assign elig     = !head.smp_miss && !head.smp_mark && (pos_ff != '0) &&
                     (pos_ff >= warm_ff) && prev_ok_ff;
   assign apply    = elig && fin_ff.rise;
   assign emit     = forced_ff || fin_ff.closed || end_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign dec_go   = (state_ff == ST_DECIDE) && (!emit || !held_vld_ff || out_free);
   assign pop      = dec_go && emit;
   assign exc      = !head.smp_miss && (head.smp_mark || apply);
   assign req_acc  = req_valid && req_ready;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // Broadcast head and start token
   always_comb begin
      bcast.head_time = head.smp_time;
      bcast.rise_lim  = {1'b0, head.smp_gl} + {1'b0, rise_ff};
      bcast.lookahead = la_ff;
      bcast.hold_secs = hold_secs_ff;
      link_start      = '0;
      link_start.vld  = start_ff;
   end

   // Cell chain
   for (genvar i = 0; i < PENDING_DEPTH; i++) begin : g_cell
      always_comb begin
         cell_ctl[i].live  = (CNT_W'(i) < count_ff);
         cell_ctl[i].load  = (state_ff == ST_LOAD) && !full && (CNT_W'(i) == count_ff);
         cell_ctl[i].pop   = pop;
         cell_ctl[i].apply = apply;
      end

      if (i == PENDING_DEPTH - 1) begin : g_tail
         gem_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (cell_ctl[i]),
            .bcast     (bcast),
            .ins_entry (ins_ff),
            .nxt_entry ('0),
            .nxt_tent  (1'b0),
            .link_prev (cell_link[i-1]),
            .entry     (cell_entry[i]),
            .tent      (cell_tent[i]),
            .link_out  (cell_link[i])
         );
      end else begin : g_body
         gem_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (cell_ctl[i]),
            .bcast     (bcast),
            .ins_entry (ins_ff),
            .nxt_entry (cell_entry[i+1]),
            .nxt_tent  (cell_tent[i+1]),
            .link_prev ((i == 0) ? link_start : cell_link[(i == 0) ? 0 : i-1]),
            .entry     (cell_entry[i]),
            .tent      (cell_tent[i]),
            .link_out  (cell_link[i])
         );
      end
   end

   // Configuration writes
   always_comb begin
      rise_in      = rise_ff;
      floor_in     = floor_ff;
      la_in        = la_ff;
      hold_secs_in = hold_secs_ff;
      warm_in      = warm_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_RISE:      rise_in      = csr_data[GL_W-1:0];
            REG_FLOOR:     floor_in     = csr_data[GL_W-1:0];
            REG_LOOKAHEAD: la_in        = csr_data[LIM_W-1:0];
            REG_HOLD:      hold_secs_in = minutes_to_secs(csr_data[MIN_W-1:0]);
            REG_WARMUP:    warm_in      = csr_data[WARM_W-1:0];
            default:       ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      prev_ok_in   = prev_ok_ff;
      trig_time_in = trig_time_ff;
      trig_act_in  = trig_act_ff;
      last_exc_in  = last_exc_ff;
      forced_in    = forced_ff;
      end_in       = end_ff;
      start_in     = 1'b0;
      fin_in       = fin_ff;
      ins_in       = ins_ff;
      held_in      = held_ff;
      held_vld_in  = held_vld_ff;
      send_held    = 1'b0;
      send_last    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               ins_in.smp_time = req_sample_time;
               ins_in.smp_gl   = req_glucose;
               ins_in.smp_miss = req_glucose_missing;
               ins_in.smp_mark = 1'b0;
               end_in          = req_series_end;
               // Carry a hold that ran past the buffer
               if (trig_act_ff) begin
                  if (!exceeds(req_sample_time, trig_time_ff, hold_secs_ff)) begin
                     ins_in.smp_mark = 1'b1;
                  end else begin
                     trig_act_in = 1'b0;
                  end
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (full) begin
               forced_in = 1'b1;
            end else begin
               forced_in = 1'b0;
               count_in  = count_ff + 1'b1;
            end
            start_in = 1'b1;
            state_in = ST_PASS;
         end
         ST_PASS: begin
            if (cell_link[PENDING_DEPTH-1].vld) begin
               fin_in   = cell_link[PENDING_DEPTH-1];
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (dec_go) begin
               if (emit) begin
                  send_held        = held_vld_ff;
                  held_in.smp_time = head.smp_time;
                  held_in.smp_gl   = head.smp_gl;
                  held_in.smp_miss = head.smp_miss;
                  held_in.exc      = exc;
                  held_in.start    = exc && !last_exc_ff;
                  held_in.slast    = end_ff && !forced_ff && (count_ff == CNT_W'(1));
                  held_vld_in      = 1'b1;
                  last_exc_in      = exc;
                  prev_ok_in       = !head.smp_miss && (head.smp_gl >= floor_ff);
                  pos_in           = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
                  if (apply && !fin_ff.hbreak) begin
                     trig_act_in  = 1'b1;
                     trig_time_in = head.smp_time;
                  end
                  count_in = count_ff - 1'b1;
                  if (forced_ff) begin
                     state_in = ST_LOAD;
                  end else if (count_ff == CNT_W'(1)) begin
                     // Buffer drained: series state back to reset
                     pos_in       = '0;
                     prev_ok_in   = 1'b0;
                     trig_time_in = '0;
                     trig_act_in  = 1'b0;
                     last_exc_in  = 1'b0;
                     state_in     = ST_FLUSH;
                  end else begin
                     start_in = 1'b1;
                     state_in = ST_PASS;
                  end
               end else begin
                  state_in = held_vld_ff ? ST_FLUSH : ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               send_held   = 1'b1;
               send_last   = 1'b1;
               held_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_pay_in   = rsp_pay_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (send_held) begin
         rsp_pay_in   = held_ff;
         rsp_last_in  = send_last;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff      <= RISE_RST;
         floor_ff     <= FLOOR_RST;
         la_ff        <= LOOKAHEAD_RST;
         hold_secs_ff <= minutes_to_secs(HOLD_MIN_RST);
         warm_ff      <= WARMUP_RST;
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         prev_ok_ff   <= 1'b0;
         trig_time_ff <= '0;
         trig_act_ff  <= 1'b0;
         last_exc_ff  <= 1'b0;
         forced_ff    <= 1'b0;
         end_ff       <= 1'b0;
         start_ff     <= 1'b0;
         fin_ff       <= '0;
         held_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rise_ff      <= rise_in;
         floor_ff     <= floor_in;
         la_ff        <= la_in;
         hold_secs_ff <= hold_secs_in;
         warm_ff      <= warm_in;
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         prev_ok_ff   <= prev_ok_in;
         trig_time_ff <= trig_time_in;
         trig_act_ff  <= trig_act_in;
         last_exc_ff  <= last_exc_in;
         forced_ff    <= forced_in;
         end_ff       <= end_in;
         start_ff     <= start_in;
         fin_ff       <= fin_in;
         held_vld_ff  <= held_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ins_ff      <= ins_in;
      held_ff     <= held_in;
      rsp_pay_ff  <= rsp_pay_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_time      = rsp_pay_ff.smp_time;
   assign rsp_out_glucose   = rsp_pay_ff.smp_gl;
   assign rsp_out_missing   = rsp_pay_ff.smp_miss;
   assign rsp_excursion     = rsp_pay_ff.exc;
   assign rsp_onset         = rsp_pay_ff.start;
   assign rsp_series_last   = rsp_pay_ff.slast;
   assign rsp_run_last      = rsp_last_ff;

   // Checks
   `GEM_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(PENDING_DEPTH))
   `GEM_ASSERT_IMP(a_idle_no_held, clock, reset, state_ff == ST_IDLE, !held_vld_ff)
   `GEM_ASSERT_IMP(a_slast_ends_run, clock, reset, rsp_valid_ff, !rsp_pay_ff.slast || rsp_last_ff)
   `GEM_ASSERT_IMP(a_start_has_exc, clock, reset, rsp_valid_ff, !rsp_pay_ff.start || rsp_pay_ff.exc)
   `GEM_ASSERT_NXT(a_load_starts_scan, clock, reset, state_ff == ST_LOAD, start_ff)

endmodule

`default_nettype wire
